@@ hw/rtl/rdmhh_pkg.sv @@
package rdmhh_pkg;

  // field widths
  localparam int unsigned STICK_W = 11;
  localparam int unsigned HEAD_W  = 9;
  localparam int unsigned ACCEL_W = 16;
  localparam int unsigned DRIVE_W = 12;
  localparam int unsigned LIMIT_W = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // fixed point integrators
  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned ACC_W         = 48;
  localparam int unsigned TENTH_SHIFT   = 16;
  localparam logic signed [13:0] TENTH_NUM = 14'sd6554;
  localparam int unsigned CLIP_W        = 24;

  // stick and heading constants
  localparam logic [STICK_W-1:0] DB_LO     = STICK_W'(1450);
  localparam logic [STICK_W-1:0] DB_HI     = STICK_W'(1550);
  localparam logic [STICK_W-1:0] CENTER    = STICK_W'(1500);
  localparam logic [STICK_W-1:0] RECAP_LO  = STICK_W'(1400);
  localparam logic [STICK_W-1:0] RECAP_HI  = STICK_W'(1600);
  localparam logic signed [HEAD_W:0] HALF_TURN = 10'sd180;
  localparam logic signed [HEAD_W:0] FULL_TURN = 10'sd360;

  // mix scaling: divide by 1.5 is 2x then /3 via reciprocal
  localparam int unsigned SUM_W       = 16;
  localparam int unsigned MAG_W       = 14;
  localparam logic [SUM_W-2:0] THIRD_RECIP = 15'd21846;
  localparam int unsigned THIRD_SHIFT = 16;

  localparam logic [DRIVE_W-1:0] DRIVE_BASE = 12'd1000;
  localparam logic [DRIVE_W-1:0] DRIVE_MAX  = 12'd4095;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd400;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACCEL_REF_X    = 2'd0,
    REG_ACCEL_REF_Y    = 2'd1,
    REG_DISTANCE_LIMIT = 2'd2
  } cfg_reg_e;

  // pipeline: stage 1 is the input register, the last one the result register
  localparam int unsigned NUM_STG = 7;

  typedef struct packed {
    logic [NUM_STG:1] en;   // stage register may load
    logic [NUM_STG:1] mv;   // a live transaction enters the stage
  } stage_ctl_t;

  typedef struct packed {
    logic               fwd_l;
    logic               fwd_r;
    logic [DRIVE_W-1:0] drive_l;
    logic [DRIVE_W-1:0] drive_r;
  } mix_out_t;

endpackage

@@ hw/rtl/rdmhh_if.sv @@
interface rdmhh_item_if import rdmhh_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [STICK_W-1:0]        stick_yaw;
  logic [STICK_W-1:0]        stick_pitch;
  logic signed [HEAD_W-1:0]  heading_deg;
  logic signed [ACCEL_W-1:0] accel_x;
  logic signed [ACCEL_W-1:0] accel_y;
  logic                      armed;

  modport source (output valid, stick_yaw, stick_pitch, heading_deg, accel_x, accel_y, armed,
                  input ready);
  modport sink   (input valid, stick_yaw, stick_pitch, heading_deg, accel_x, accel_y, armed,
                  output ready);
endinterface

interface rdmhh_result_if import rdmhh_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               left_forward;
  logic               right_forward;
  logic [DRIVE_W-1:0] left_drive;
  logic [DRIVE_W-1:0] right_drive;
  logic               rover_active;
  logic               takeoff_request;

  modport source (output valid, left_forward, right_forward, left_drive, right_drive,
                  rover_active, takeoff_request, input ready);
  modport sink   (input valid, left_forward, right_forward, left_drive, right_drive,
                  rover_active, takeoff_request, output ready);
endinterface

interface rdmhh_cfg_if import rdmhh_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ hw/rtl/rdmhh_mix.sv @@
module rdmhh_mix import rdmhh_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  stage_ctl_t               ctl_i,
  input  logic [STICK_W-1:0]       stick_yaw_i,
  input  logic [STICK_W-1:0]       stick_pitch_i,
  input  logic signed [HEAD_W-1:0] heading_i,
  output mix_out_t                 mix_o
);

  function automatic logic signed [STICK_W:0] stick_ofs(input logic [STICK_W-1:0] v);
    logic [STICK_W-1:0] d;
    d = (v > DB_LO && v < DB_HI) ? CENTER : v;
    return $signed({1'b0, d}) - $signed({1'b0, CENTER});
  endfunction

  // floor(|x| / 3), exact for |x| below 2^15
  function automatic logic [MAG_W-1:0] third_mag(input logic signed [SUM_W-1:0] x);
    logic [SUM_W-2:0]   a;
    logic [2*SUM_W-3:0] p;
    a = x[SUM_W-1] ? (SUM_W-1)'(-x) : x[SUM_W-2:0];
    p = a * THIRD_RECIP;
    return p[THIRD_SHIFT +: MAG_W];
  endfunction

  function automatic logic [DRIVE_W-1:0] drive_of(input logic [MAG_W-1:0] m);
    logic [MAG_W:0] s;
    s = {{(MAG_W+1-DRIVE_W){1'b0}}, DRIVE_BASE} + {1'b0, m};
    return (s > {{(MAG_W+1-DRIVE_W){1'b0}}, DRIVE_MAX}) ? DRIVE_MAX : s[DRIVE_W-1:0];
  endfunction

  // stage 1: input register
  logic [STICK_W-1:0]       yaw1_q, pitch1_q;
  logic signed [HEAD_W-1:0] head1_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[1]) begin
      yaw1_q   <= stick_yaw_i;
      pitch1_q <= stick_pitch_i;
      head1_q  <= heading_i;
    end
  end

  // held heading; also tracks outside rover mode, where it is never looked at again
  logic signed [HEAD_W-1:0] held_q, held_d;
  logic signed [HEAD_W:0]   err_raw, err;
  logic signed [SUM_W-1:0]  pe, ye, ee, suml_d, sumr_d;

  always_comb begin
    held_d  = (yaw1_q > RECAP_HI || yaw1_q < RECAP_LO) ? head1_q : held_q;
    err_raw = {held_d[HEAD_W-1], held_d} - {head1_q[HEAD_W-1], head1_q};
    if (err_raw > HALF_TURN) begin
      err = err_raw - FULL_TURN;
    end else if (err_raw < -HALF_TURN) begin
      err = err_raw + FULL_TURN;
    end else begin
      err = err_raw;
    end
    pe = SUM_W'(stick_ofs(pitch1_q));
    ye = SUM_W'(stick_ofs(yaw1_q));
    ee = SUM_W'(err);
    suml_d = ((pe <<< 1) + ye + ee * 16'sd10) <<< 1;
    sumr_d = ((pe <<< 1) - ye - ee * 16'sd10) <<< 1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
    end else if (ctl_i.mv[2]) begin
      held_q <= held_d;
    end
  end

  // stage 2: mix sums
  logic signed [SUM_W-1:0] suml2_q, sumr2_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[2]) begin
      suml2_q <= suml_d;
      sumr2_q <= sumr_d;
    end
  end

  // stage 3: truncated quotients as sign and magnitude
  logic [MAG_W-1:0] magl_d, magr_d, magl3_q, magr3_q;
  logic             posl3_q, posr3_q;

  assign magl_d = third_mag(suml2_q);
  assign magr_d = third_mag(sumr2_q);

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[3]) begin
      magl3_q <= magl_d;
      magr3_q <= magr_d;
      posl3_q <= !suml2_q[SUM_W-1] && (magl_d != '0);
      posr3_q <= !sumr2_q[SUM_W-1] && (magr_d != '0);
    end
  end

  // stage 4 builds the drive pulses, stages 5 and 6 keep pace with the distance path
  mix_out_t out4_q, out5_q, out6_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[4]) begin
      out4_q.fwd_l   <= posl3_q;
      out4_q.fwd_r   <= posr3_q;
      out4_q.drive_l <= drive_of(magl3_q);
      out4_q.drive_r <= drive_of(magr3_q);
    end
    if (ctl_i.en[5]) begin
      out5_q <= out4_q;
    end
    if (ctl_i.en[6]) begin
      out6_q <= out5_q;
    end
  end

  assign mix_o = out6_q;

endmodule

@@ hw/rtl/rdmhh_odo.sv @@
module rdmhh_odo import rdmhh_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  stage_ctl_t                ctl_i,
  input  logic signed [ACCEL_W-1:0] accel_x_i,
  input  logic signed [ACCEL_W-1:0] accel_y_i,
  input  logic                      armed_i,
  input  logic signed [ACCEL_W-1:0] ref_x_i,
  input  logic signed [ACCEL_W-1:0] ref_y_i,
  input  logic [LIMIT_W-1:0]        limit_i,
  output logic                      exceed_o
);

  localparam int unsigned PROD_W = ACCEL_W + 1 + 14;
  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] CLIP_MAX = ACC_W'((1 << (CLIP_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] CLIP_MIN = -ACC_W'(1 << (CLIP_W - 1));

  function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] a,
                                                      input logic signed [ACC_W-1:0] b);
    logic signed [ACC_W:0] s;
    s = (ACC_W+1)'(a) + (ACC_W+1)'(b);
    if (s[ACC_W] != s[ACC_W-1]) begin
      return s[ACC_W] ? ACC_MIN : ACC_MAX;
    end
    return s[ACC_W-1:0];
  endfunction

  // acceleration step: floor(prod * 2^FRAC_BITS / 2^16)
  function automatic logic signed [ACC_W-1:0] accel_step(input logic signed [PROD_W-1:0] p);
    logic signed [63:0] w;
    w = 64'(p);
    w = (w <<< FRAC_BITS) >>> TENTH_SHIFT;
    return w[ACC_W-1:0];
  endfunction

  // floor(v * 6554 / 65536)
  function automatic logic signed [ACC_W-1:0] tenth(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W+13:0] p;
    p = v * TENTH_NUM;
    return ACC_W'(p >>> TENTH_SHIFT);
  endfunction

  function automatic logic signed [CLIP_W-1:0] int_clip(input logic signed [ACC_W-1:0] d);
    logic signed [ACC_W-1:0] q;
    q = d >>> FRAC_BITS;
    if (q > CLIP_MAX) begin
      q = CLIP_MAX;
    end else if (q < CLIP_MIN) begin
      q = CLIP_MIN;
    end
    return q[CLIP_W-1:0];
  endfunction

  // stage 1: input register
  logic signed [ACCEL_W-1:0] ax1_q, ay1_q;
  logic                      arm1_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[1]) begin
      ax1_q  <= accel_x_i;
      ay1_q  <= accel_y_i;
      arm1_q <= armed_i;
    end
  end

  // stage 2: offset removal and scaling by 0.1
  logic signed [PROD_W-1:0] px2_q, py2_q;
  logic                     arm2_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[2]) begin
      px2_q  <= ((ACCEL_W+1)'(ax1_q) - (ACCEL_W+1)'(ref_x_i)) * TENTH_NUM;
      py2_q  <= ((ACCEL_W+1)'(ay1_q) - (ACCEL_W+1)'(ref_y_i)) * TENTH_NUM;
      arm2_q <= arm1_q;
    end
  end

  // stage 3: velocity integrators
  logic signed [ACC_W-1:0] vx_q, vy_q;
  logic                    arm3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vx_q <= '0;
      vy_q <= '0;
    end else if (ctl_i.mv[3]) begin
      vx_q <= arm2_q ? sat_add(vx_q, accel_step(px2_q)) : '0;
      vy_q <= arm2_q ? sat_add(vy_q, accel_step(py2_q)) : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[3]) begin
      arm3_q <= arm2_q;
    end
  end

  // stage 4: velocity times 0.1; vx_q still holds this transaction's velocity
  logic signed [ACC_W-1:0] tx4_q, ty4_q;
  logic                    arm4_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[4]) begin
      tx4_q  <= tenth(vx_q);
      ty4_q  <= tenth(vy_q);
      arm4_q <= arm3_q;
    end
  end

  // stage 5: distance integrators
  logic signed [ACC_W-1:0] dx_q, dy_q;
  logic                    arm5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dx_q <= '0;
      dy_q <= '0;
    end else if (ctl_i.mv[5]) begin
      dx_q <= arm4_q ? sat_add(dx_q, tx4_q) : '0;
      dy_q <= arm4_q ? sat_add(dy_q, ty4_q) : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[5]) begin
      arm5_q <= arm4_q;
    end
  end

  // stage 6: squared integer distances and squared limit
  logic signed [CLIP_W-1:0]   ix, iy;
  logic signed [2*CLIP_W-1:0] sqx_d, sqy_d;
  logic [2*CLIP_W-1:0]        sqx6_q, sqy6_q;
  logic [2*LIMIT_W-1:0]       lim6_q;
  logic                       arm6_q;

  assign ix    = int_clip(dx_q);
  assign iy    = int_clip(dy_q);
  assign sqx_d = ix * ix;
  assign sqy_d = iy * iy;

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[6]) begin
      sqx6_q <= $unsigned(sqx_d);
      sqy6_q <= $unsigned(sqy_d);
      lim6_q <= limit_i * limit_i;
      arm6_q <= arm5_q;
    end
  end

  assign exceed_o = arm6_q &&
                    (({1'b0, sqx6_q} + {1'b0, sqy6_q}) > (2*CLIP_W+1)'(lim6_q));

endmodule

@@ hw/rtl/rover_drive_mixer_heading_hold.sv @@
// Rover drive mixer with heading hold and distance-triggered takeoff request. One
// transaction per clock is accepted unless the pipeline is full and stalled, and each
// produces exactly one result, held until the result side is ready; stalls on the
// result side back up through a seven-stage valid/ready pipeline whose empty slots keep
// absorbing input. The sustained rate is set by the two integrator recurrences
// (velocity, then distance), each of which closes in a single saturating 48-bit add per
// cycle. Configuration writes are always accepted. The acceleration offsets are read
// in stage 2 and the distance limit in stage 6, so write them only with no transaction in
// flight. Distances use FRAC_BITS fraction bits; the squared distance test is exact.
module rover_drive_mixer_heading_hold import rdmhh_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  rdmhh_item_if.sink     item_i,
  rdmhh_result_if.source result_o,
  rdmhh_cfg_if.sink      cfg_i
);

  // configuration registers
  logic signed [ACCEL_W-1:0] ref_x_q, ref_y_q;
  logic [LIMIT_W-1:0]        limit_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_x_q <= '0;
      ref_y_q <= '0;
      limit_q <= LIMIT_RESET;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.index)
        REG_ACCEL_REF_X:    ref_x_q <= $signed(cfg_i.data[ACCEL_W-1:0]);
        REG_ACCEL_REF_Y:    ref_y_q <= $signed(cfg_i.data[ACCEL_W-1:0]);
        REG_DISTANCE_LIMIT: limit_q <= cfg_i.data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline valid/ready chain
  logic [NUM_STG:1] vld_q, vld_in, rdy;
  stage_ctl_t       ctl;

  assign vld_in = {vld_q[NUM_STG-1:1], item_i.valid};

  always_comb begin
    rdy[NUM_STG] = !vld_q[NUM_STG] || result_o.ready;
    for (int k = NUM_STG - 1; k >= 1; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  assign ctl.en       = rdy;
  assign ctl.mv       = rdy & vld_in;
  assign item_i.ready = rdy[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= (rdy & vld_in) | (~rdy & vld_q);
    end
  end

  mix_out_t mix;
  logic     exceed;

  rdmhh_mix u_mix (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .stick_yaw_i   (item_i.stick_yaw),
    .stick_pitch_i (item_i.stick_pitch),
    .heading_i     (item_i.heading_deg),
    .mix_o         (mix)
  );

  rdmhh_odo #(
    .FRAC_BITS (FRAC_BITS)
  ) u_odo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl),
    .accel_x_i (item_i.accel_x),
    .accel_y_i (item_i.accel_y),
    .armed_i   (item_i.armed),
    .ref_x_i   (ref_x_q),
    .ref_y_i   (ref_y_q),
    .limit_i   (limit_q),
    .exceed_o  (exceed)
  );

  // result register and rover mode flag; the flag never returns to 1 before reset
  logic               rover_q, rover_next;
  logic               lf_q, rf_q, act_q, tko_q;
  logic [DRIVE_W-1:0] ld_q, rd_q;

  assign rover_next = rover_q && !exceed;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rover_q <= 1'b1;
    end else if (ctl.mv[NUM_STG]) begin
      rover_q <= rover_next;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.en[NUM_STG]) begin
      // the tick that ends rover mode keeps its direction bits but idles the drives
      lf_q  <= rover_q && mix.fwd_l;
      rf_q  <= rover_q && mix.fwd_r;
      ld_q  <= rover_next ? mix.drive_l : DRIVE_BASE;
      rd_q  <= rover_next ? mix.drive_r : DRIVE_BASE;
      act_q <= rover_next;
      tko_q <= exceed;
    end
  end

  assign result_o.valid           = vld_q[NUM_STG];
  assign result_o.left_forward    = lf_q;
  assign result_o.right_forward   = rf_q;
  assign result_o.left_drive      = ld_q;
  assign result_o.right_drive     = rd_q;
  assign result_o.rover_active    = act_q;
  assign result_o.takeoff_request = tko_q;

`ifndef NO_ASSERTIONS
  a_rover_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rover_q |=> !rover_q)
    else $error("rover mode re-entered without reset");

  a_takeoff_ends_rover: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.takeoff_request) |-> !result_o.rover_active)
    else $error("takeoff request while still in rover mode");

  a_drive_only_in_rover: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && (result_o.left_drive != DRIVE_BASE ||
                        result_o.right_drive != DRIVE_BASE))
    |-> (result_o.rover_active && !result_o.takeoff_request))
    else $error("drive command outside rover mode");
`endif

endmodule

@@ sim/tb_rover_drive_mixer_heading_hold.sv @@
`timescale 1ns / 1ps

module tb_rover_drive_mixer_heading_hold;
  import rdmhh_pkg::*;

  localparam int     FRAC       = FRAC_BITS_DEF;
  localparam int     MAX_CYCLES = 200000;
  localparam int     DRAIN_WAIT = 12;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam longint ACC_HI    = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint ACC_LO    = -ACC_HI - 1;
  localparam longint WHOLE_HI  = 64'sd8388607;
  localparam longint WHOLE_LO  = -64'sd8388608;
  localparam longint TENTH_MUL = 6554;
  localparam int     TENTH_SH  = 16;

  typedef struct {
    logic [STICK_W-1:0]        yaw;
    logic [STICK_W-1:0]        pitch;
    logic signed [HEAD_W-1:0]  heading;
    logic signed [ACCEL_W-1:0] ax;
    logic signed [ACCEL_W-1:0] ay;
    logic                      armed;
  } tick_t;

  typedef struct {
    logic               lf;
    logic               rf;
    logic [DRIVE_W-1:0] ld;
    logic [DRIVE_W-1:0] rd;
    logic               rover;
    logic               takeoff;
  } drive_t;

  class mixer_scoreboard;
    longint ref_x, ref_y, dist_limit;
    longint held, vel_x, vel_y, pos_x, pos_y;
    bit     rover;
    drive_t drive_q[$];
    int     errors;
    int     checked;

    function new();
      ref_x = 0;
      ref_y = 0;
      dist_limit = 400;
      held = 0;
      vel_x = 0;
      vel_y = 0;
      pos_x = 0;
      pos_y = 0;
      rover = 1'b1;
      errors = 0;
      checked = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_ACCEL_REF_X:    ref_x = $signed(data);
        REG_ACCEL_REF_Y:    ref_y = $signed(data);
        REG_DISTANCE_LIMIT: dist_limit = data;
        default: ;
      endcase
    endfunction

    // floor(v * 0.1) with 0.1 as 6554/65536
    static function longint tenth(longint v);
      return (v * TENTH_MUL) >>> TENTH_SH;
    endfunction

    static function longint sat48(longint s);
      if (s > ACC_HI) return ACC_HI;
      if (s < ACC_LO) return ACC_LO;
      return s;
    endfunction

    static function longint whole(longint d);
      longint q;
      q = d >>> FRAC;
      if (q > WHOLE_HI) q = WHOLE_HI;
      if (q < WHOLE_LO) q = WHOLE_LO;
      return q;
    endfunction

    static function longint dband(longint v);
      return (v > 1450 && v < 1550) ? 1500 : v;
    endfunction

    static function logic [DRIVE_W-1:0] pulse(longint m);
      longint v;
      v = 1000 + ((m < 0) ? -m : m);
      if (v > 4095) return 12'd4095;
      return v[DRIVE_W-1:0];
    endfunction

    function drive_t mix_tick(tick_t t);
      drive_t r;
      longint yaw, pitch, hd, err, p, y, m2, m3, ix, iy;
      yaw = t.yaw;
      pitch = t.pitch;
      hd = t.heading;
      r.lf = 1'b0;
      r.rf = 1'b0;
      r.ld = 12'd1000;
      r.rd = 12'd1000;
      r.takeoff = 1'b0;
      if (rover) begin
        if (yaw > 1600 || yaw < 1400) held = hd;
        err = held - hd;
        if (err > 180) err -= 360;
        else if (err < -180) err += 360;
        p = dband(pitch) - 1500;
        y = dband(yaw) - 1500;
        m2 = ((2 * p + y + 10 * err) * 2) / 3;
        m3 = -(((2 * p - y - 10 * err) * 2) / 3);
        r.lf = (m2 > 0);
        r.rf = (m3 < 0);
        r.ld = pulse(m2);
        r.rd = pulse(m3);
      end
      if (t.armed) begin
        vel_x = sat48(vel_x + tenth((longint'(t.ax) - ref_x) <<< FRAC));
        vel_y = sat48(vel_y + tenth((longint'(t.ay) - ref_y) <<< FRAC));
        pos_x = sat48(pos_x + tenth(vel_x));
        pos_y = sat48(pos_y + tenth(vel_y));
        ix = whole(pos_x);
        iy = whole(pos_y);
        if (ix * ix + iy * iy > dist_limit * dist_limit) begin
          rover = 1'b0;
          r.takeoff = 1'b1;
          r.ld = 12'd1000;
          r.rd = 12'd1000;
        end
      end else begin
        vel_x = 0;
        vel_y = 0;
        pos_x = 0;
        pos_y = 0;
      end
      r.rover = rover;
      return r;
    endfunction

    function void note_tick(tick_t t);
      drive_q.push_back(mix_tick(t));
    endfunction

    function int pending();
      return drive_q.size();
    endfunction

    function void field_check(string name, longint want, longint got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_drive(drive_t got);
      drive_t want;
      checked++;
      if (drive_q.size() == 0) begin
        $error("result with no transaction outstanding");
        errors++;
        return;
      end
      want = drive_q.pop_front();
      field_check("left_forward", want.lf, got.lf);
      field_check("right_forward", want.rf, got.rf);
      field_check("left_drive", want.ld, got.ld);
      field_check("right_drive", want.rd, got.rd);
      field_check("rover_active", want.rover, got.rover);
      field_check("takeoff_request", want.takeoff, got.takeoff);
    endfunction
  endclass

  logic clk;
  logic rst_n;

  rdmhh_item_if   item_if();
  rdmhh_result_if res_if();
  rdmhh_cfg_if    cfg_if();

  rover_drive_mixer_heading_hold uut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .item_i   (item_if),
    .result_o (res_if),
    .cfg_i    (cfg_if)
  );

  mixer_scoreboard sb = new();
  int burst_left;
  int cycles;
  bit pressure_done;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > MAX_CYCLES) begin
        $display("FAIL rover_drive_mixer_heading_hold");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    drive_t got;
    if (rst_n && res_if.valid && res_if.ready) begin
      got.lf = res_if.left_forward;
      got.rf = res_if.right_forward;
      got.ld = res_if.left_drive;
      got.rd = res_if.right_drive;
      got.rover = res_if.rover_active;
      got.takeoff = res_if.takeoff_request;
      sb.check_drive(got);
    end
  end

  // result side: changing stall patterns, plus one long hold-off to back up the pipe
  initial begin
    int mode, left, hold;
    res_if.ready = 1'b0;
    mode = 0;
    left = 0;
    hold = 0;
    pressure_done = 1'b0;
    forever begin
      @(negedge clk);
      if (!pressure_done && sb.checked >= 400) begin
        pressure_done = 1'b1;
        hold = 300;
      end
      if (hold > 0) begin
        hold--;
        res_if.ready <= 1'b0;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(16, 128);
        end
        left--;
        case (mode)
          0: res_if.ready <= 1'b1;
          1: res_if.ready <= ($urandom_range(0, 9) < 7);
          2: res_if.ready <= ($urandom_range(0, 9) < 3);
          default: res_if.ready <= (left % 5 >= 2);
        endcase
      end
    end
  end

  task automatic send_tick(input tick_t t);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk);
        item_if.valid <= 1'b0;
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    @(negedge clk);
    item_if.valid       <= 1'b1;
    item_if.stick_yaw   <= t.yaw;
    item_if.stick_pitch <= t.pitch;
    item_if.heading_deg <= t.heading;
    item_if.accel_x     <= t.ax;
    item_if.accel_y     <= t.ay;
    item_if.armed       <= t.armed;
    @(posedge clk);
    while (!item_if.ready) @(posedge clk);
    sb.note_tick(t);
  endtask

  task automatic hold_sender();
    @(negedge clk);
    item_if.valid <= 1'b0;
    burst_left = 0;
  endtask

  // registers only change with the pipe empty
  task automatic settle();
    hold_sender();
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic configure(input logic [15:0] rx, input logic [15:0] ry, input logic [15:0] lim);
    settle();
    write_reg(REG_ACCEL_REF_X, rx);
    write_reg(REG_ACCEL_REF_Y, ry);
    write_reg(REG_DISTANCE_LIMIT, lim);
  endtask

  function automatic logic [STICK_W-1:0] pick_stick();
    int marks[14] = '{0, 1399, 1400, 1401, 1449, 1450, 1451,
                      1549, 1550, 1551, 1599, 1600, 1601, 2047};
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return STICK_W'($urandom_range(1000, 2000));
      5, 6:          return STICK_W'($urandom_range(1380, 1620));
      7:             return STICK_W'($urandom_range(0, 2047));
      8:             return STICK_W'(marks[$urandom_range(0, 13)]);
      default:       return 11'd1500;
    endcase
  endfunction

  function automatic logic signed [HEAD_W-1:0] pick_heading();
    case ($urandom_range(0, 9))
      8:       return HEAD_W'($urandom_range(0, 511));
      9:       return $urandom_range(0, 1) ? 9'sd180 : -9'sd180;
      default: return HEAD_W'(int'($urandom_range(0, 360)) - 180);
    endcase
  endfunction

  function automatic logic signed [ACCEL_W-1:0] clip16(longint v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return v[ACCEL_W-1:0];
  endfunction

  function automatic tick_t loose_tick(bit armed);
    tick_t t;
    t.yaw = pick_stick();
    t.pitch = pick_stick();
    t.heading = pick_heading();
    t.ax = ACCEL_W'($urandom);
    t.ay = ACCEL_W'($urandom);
    t.armed = armed;
    return t;
  endfunction

  function automatic tick_t make_tick(int yaw, int pitch, int heading, int ax, int ay, bit armed);
    tick_t t;
    t.yaw = STICK_W'(yaw);
    t.pitch = STICK_W'(pitch);
    t.heading = HEAD_W'(heading);
    t.ax = ACCEL_W'(ax);
    t.ay = ACCEL_W'(ay);
    t.armed = armed;
    return t;
  endfunction

  // armed runs around the reference plus offset, each closed by a disarmed tick;
  // small spans with short runs keep the distance well under a 65535 limit
  task automatic drive_stream(input int n, input int span, input int max_run);
    int sent, len, jit;
    longint bx, by;
    tick_t t;
    sent = 0;
    jit = (span > 4000) ? 256 : 50;
    while (sent < n) begin
      if ($urandom_range(0, 3) == 0) begin
        send_tick(loose_tick((span > 4000) && ($urandom_range(0, 1) == 1)));
        sent++;
      end else begin
        len = $urandom_range(1, max_run);
        bx = longint'($urandom_range(0, 2 * span)) - span;
        by = longint'($urandom_range(0, 2 * span)) - span;
        repeat (len) begin
          t = loose_tick(1'b1);
          t.ax = clip16(sb.ref_x + bx + longint'($urandom_range(0, 2 * jit)) - jit);
          t.ay = clip16(sb.ref_y + by + longint'($urandom_range(0, 2 * jit)) - jit);
          send_tick(t);
          sent++;
        end
        send_tick(loose_tick(1'b0));
        sent++;
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    item_if.valid = 1'b0;
    item_if.stick_yaw = '0;
    item_if.stick_pitch = '0;
    item_if.heading_deg = '0;
    item_if.accel_x = '0;
    item_if.accel_y = '0;
    item_if.armed = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    burst_left = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed, reset configuration
    send_tick(make_tick(1000, 1500, 0, 0, 0, 0));
    send_tick(make_tick(1500, 2000, 0, 0, 0, 0));
    send_tick(make_tick(1500, 1000, 0, 0, 0, 0));
    send_tick(make_tick(2000, 1500, 180, 0, 0, 0));
    send_tick(make_tick(1500, 1500, -180, 0, 0, 0));      // error of 360 wraps to 0
    send_tick(make_tick(1460, 1540, 90, 0, 0, 0));        // both in deadband
    send_tick(make_tick(1450, 1550, -90, 0, 0, 0));       // deadband edges
    send_tick(make_tick(1400, 1449, 255, 32767, -32768, 0));
    send_tick(make_tick(1600, 1551, -256, -32768, 32767, 0));
    send_tick(make_tick(1000, 1500, -180, 0, 0, 0));
    send_tick(make_tick(1500, 1500, 100, 0, 0, 0));       // error below -180 wraps up
    send_tick(make_tick(1601, 1500, 0, 0, 0, 0));
    send_tick(make_tick(1400, 0, 180, 0, 0, 0));          // left drive saturates
    send_tick(make_tick(1600, 0, -180, 0, 0, 0));         // right drive saturates
    send_tick(make_tick(0, 0, 0, 0, 0, 0));
    send_tick(make_tick(2047, 2047, 255, 0, 0, 0));
    send_tick(make_tick(1500, 1500, 0, 5, -3, 1));
    send_tick(make_tick(1500, 1500, 0, 5, -3, 1));
    send_tick(make_tick(1500, 1500, 0, 0, 0, 0));

    configure(16'sh8000, 16'sh7FFF, 16'hFFFF);
    drive_stream(300, 2000, 40);

    configure(16'($urandom), 16'($urandom), 16'hFFFF);
    write_reg(REG_UNUSED, 16'($urandom));
    drive_stream(500, 2000, 40);

    // zero limit: any nonzero distance ends rover mode
    configure(16'd0, 16'd0, 16'd0);
    send_tick(make_tick(1000, 1800, 30, -1, 0, 1));
    send_tick(make_tick(1500, 1500, 30, -1, 0, 1));
    send_tick(make_tick(2047, 0, -256, 0, 0, 0));
    send_tick(make_tick(1500, 1500, 0, 0, 0, 1));          // distance equals limit
    configure(16'd0, 16'd0, 16'd1);
    send_tick(make_tick(1500, 1500, 0, 100, 0, 1));
    send_tick(make_tick(1500, 1500, 0, 100, 0, 1));
    send_tick(make_tick(1500, 1500, 0, 0, 0, 0));

    for (int k = 0; k < 6; k++) begin
      case (k)
        0: configure(16'sh7FFF, 16'sh8000, 16'hFFFF);
        1: configure(16'sh8000, 16'sh7FFF, 16'd0);
        2: configure(16'd0, 16'd0, 16'($urandom_range(1, 1000)));
        default: configure(16'($urandom), 16'($urandom), 16'($urandom));
      endcase
      drive_stream(170, 65535, 250);
    end

    hold_sender();
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.errors == 0) begin
      $display("PASS rover_drive_mixer_heading_hold");
    end else begin
      $display("FAIL rover_drive_mixer_heading_hold");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/rdmhh_pkg.sv
hw/rtl/rdmhh_if.sv
hw/rtl/rdmhh_mix.sv
hw/rtl/rdmhh_odo.sv
hw/rtl/rover_drive_mixer_heading_hold.sv
sim/tb_rover_drive_mixer_heading_hold.sv
